### rtl/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPLIES(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("lbl");
`define ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("lbl");
`endif

### rtl/ppal_pkg.sv
package ppal_pkg;
   localparam int MAX_PIXELS_DEF    = 65536;
   localparam int PALETTE_DEPTH_DEF = 256;
   localparam logic [1:0] REQ_PUSH = 2'd0;
   localparam logic [1:0] REQ_IMG  = 2'd1;
   localparam logic [1:0] REQ_PAL  = 2'd2;
   localparam logic [2:0] FMT_2BPP = 3'd0;
   localparam logic [2:0] FMT_4BPP = 3'd1;
   localparam logic [2:0] FMT_8BPP = 3'd2;
   localparam logic [2:0] FMT_RGB  = 3'd3;
   localparam logic [2:0] FMT_RGBA = 3'd4;
endpackage

### rtl/ppal_store.sv
// colour and index stores, one write port, one registered read port
module ppal_store import ppal_pkg::*; #(
   parameter int AW = 16
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [15:0]   wr_colour,
   input  logic [7:0]    wr_index,
   input  logic [AW-1:0] rd_addr,
   output logic [15:0]   rd_colour,
   output logic [7:0]    rd_index
);
   logic [15:0] colour_mem [2**AW];
   logic [7:0]  index_mem  [2**AW];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         colour_mem[wr_addr] <= wr_colour;
         index_mem[wr_addr]  <= wr_index;
      end
      rd_colour <= colour_mem[rd_addr];
      rd_index  <= index_mem[rd_addr];
   end
endmodule

### rtl/pixel_palettizer.sv
// pixel_palettizer: turns rgb/rgba pixels into rgb555+alpha colours and a palette.
// req channel (req_valid/req_stall): req_type 0 pushes a pixel, 1 reads a
// packed image byte or direct colour word, 2 reads a palette entry.
// rsp channel (rsp_valid/rsp_stall): one transaction per request carrying
// palette_count, overflow, format, image_done, pixel_count and read_data.
// csr_wr_en/csr_wr_data write the channels register (3 rgb, else rgba).
// an opaque push searches the palette one entry per cycle; a transparent push,
// or any push once the palette has overflowed, skips the search. an image
// read fetches one stored pixel in 8bpp and direct, two in 4bpp and four in
// 2bpp (each through S_IMG then S_RDW), a palette read one registered entry.
// one transaction is in flight at a time; req_stall is high while busy.
// reset clears palette count to 1, pixel count, overflow and done;
// the stores are not cleared, reads are bounded by the counts.
// while rsp_stall is high the result is held and no new request is taken.
module pixel_palettizer import ppal_pkg::*; #(
   parameter int MAX_PIXELS    = MAX_PIXELS_DEF,
   parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [7:0]  red,
   input  logic [7:0]  green,
   input  logic [7:0]  blue,
   input  logic [7:0]  alpha,
   input  logic        last,
   input  logic [15:0] index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [8:0]  palette_count,
   output logic        overflow,
   output logic [2:0]  format,
   output logic        image_done,
   output logic [16:0] pixel_count,
   output logic [15:0] read_data
);
`include "assert_macros.svh"
   localparam int AW = $clog2(MAX_PIXELS);
   localparam int PW = $clog2(PALETTE_DEPTH);
   localparam int CW = AW + 1;

   typedef enum logic [2:0] {S_IDLE, S_SRCH, S_RDW, S_IMG, S_PAL, S_RSP} state_type;

   state_type   state_ff, state_in;
   logic [2:0]  chan_ff;
   logic [8:0]  used_ff, used_in;
   logic        ovf_ff, ovf_in, done_ff, done_in;
   logic [CW-1:0] taken_ff, taken_in;
   logic [15:0] col_ff, col_in;
   logic        last_ff, last_in;
   logic [15:0] k_ff, k_in;
   logic [PW:0] ptr_ff, ptr_in;
   logic [2:0]  sub_ff, sub_in;
   logic [15:0] data_ff, data_in;
   logic [15:0] pal_mem [PALETTE_DEPTH];
   logic [15:0] pal_rd;
   logic        pal_we;
   logic [PW-1:0] pal_waddr, pal_raddr;
   logic        st_we;
   logic [7:0]  st_widx;
   logic [AW-1:0] st_raddr;
   logic [15:0] st_rcol;
   logic [7:0]  st_ridx;
   logic [2:0]  fmt;
   logic [19:0] paddr;      // pixel address of current packed slot
   logic        pvalid_ff, pvalid_in;

   always_ff @(posedge clock) begin
      if (pal_we) pal_mem[pal_waddr] <= col_ff;
      pal_rd <= pal_mem[pal_raddr];
   end

   ppal_store #(.AW(AW)) u_store (
      .clock(clock), .wr_en(st_we), .wr_addr(taken_ff[AW-1:0]),
      .wr_colour(col_ff), .wr_index(st_widx),
      .rd_addr(st_raddr), .rd_colour(st_rcol), .rd_index(st_ridx));

   always_comb begin
      if (ovf_ff) fmt = (chan_ff == 3'd3) ? FMT_RGB : FMT_RGBA;
      else if (used_ff <= 9'd4) fmt = FMT_2BPP;
      else if (used_ff <= 9'd16) fmt = FMT_4BPP;
      else fmt = FMT_8BPP;
   end

   always_comb begin
      case (fmt)
         FMT_2BPP: paddr = {2'd0, k_ff, 2'b00} + {17'd0, sub_ff};
         FMT_4BPP: paddr = {3'd0, k_ff, 1'b0} + {17'd0, sub_ff};
         default:  paddr = {4'd0, k_ff};
      endcase
   end

   always_comb begin
      state_in = state_ff; used_in = used_ff; ovf_in = ovf_ff; done_in = done_ff;
      taken_in = taken_ff; col_in = col_ff; last_in = last_ff;
      k_in = k_ff; ptr_in = ptr_ff; sub_in = sub_ff; data_in = data_ff;
      pvalid_in = 1'b0;
      pal_we = 1'b0; pal_waddr = used_ff[PW-1:0]; pal_raddr = ptr_ff[PW-1:0];
      st_we = 1'b0; st_widx = 8'd0; st_raddr = paddr[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               k_in = index; last_in = last; data_in = 16'd0;
               col_in = {(chan_ff == 3'd3) ? 1'b1 : alpha[7], blue[7:3], green[7:3], red[7:3]};
               sub_in = 3'd0; ptr_in = (PW+1)'(1);
               case (req_type)
                  REQ_PUSH: begin
                     if (done_ff) begin
                        used_in = 9'd1; ovf_in = 1'b0; taken_in = '0; done_in = 1'b0;
                     end
                     state_in = S_SRCH;
                  end
                  REQ_IMG: begin
                     pvalid_in = 1'b0;
                     state_in = S_IMG;
                  end
                  REQ_PAL: begin
                     pal_raddr = index[PW-1:0];
                     state_in = S_PAL;
                  end
                  default: state_in = S_RSP;
               endcase
            end
         end
         S_SRCH: begin
            // ptr_ff: entry whose read is issued now; pal_rd holds entry ptr_ff-1
            if (pvalid_ff && pal_rd == col_ff) begin
               st_we = 1'b1; st_widx = 8'(ptr_ff - (PW+1)'(1));
               taken_in = taken_ff + CW'(1);
               if (last_ff) done_in = 1'b1;
               state_in = S_RSP;
            end else if (taken_ff >= CW'(MAX_PIXELS)) begin
               if (last_ff) done_in = 1'b1;
               state_in = S_RSP;
            end else if (!col_ff[15] || ovf_ff) begin
               st_we = 1'b1; taken_in = taken_ff + CW'(1);
               if (last_ff) done_in = 1'b1;
               state_in = S_RSP;
            end else if (ptr_ff >= used_ff[PW:0]) begin
               // no used entry left to compare
               st_we = 1'b1;
               if (used_ff < 9'(PALETTE_DEPTH)) begin
                  pal_we = 1'b1; st_widx = used_ff[7:0]; used_in = used_ff + 9'd1;
               end else ovf_in = 1'b1;
               taken_in = taken_ff + CW'(1);
               if (last_ff) done_in = 1'b1;
               state_in = S_RSP;
            end else begin
               pvalid_in = 1'b1;
               ptr_in = ptr_ff + (PW+1)'(1);
            end
         end
         S_IMG: begin
            // sub_ff selects pixel; data returns next cycle
            state_in = S_RDW;
         end
         S_RDW: begin
            if (fmt >= FMT_RGB) begin
               if ({4'd0, k_ff} < 20'(taken_ff)) data_in = st_rcol;
               state_in = S_RSP;
            end else begin
               if (paddr < 20'(taken_ff)) begin
                  case (fmt)
                     FMT_2BPP: data_in = data_ff | (16'(st_ridx[1:0]) << {sub_ff, 1'b0});
                     FMT_4BPP: data_in = data_ff | (16'(st_ridx[3:0]) << {sub_ff, 2'b00});
                     default:  data_in = 16'(st_ridx);
                  endcase
               end
               if ((fmt == FMT_2BPP && sub_ff != 3'd3) ||
                   (fmt == FMT_4BPP && sub_ff != 3'd1)) begin
                  sub_in = sub_ff + 3'd1; state_in = S_IMG;
               end else state_in = S_RSP;
            end
         end
         S_PAL: begin
            if (k_ff < {7'd0, used_ff} && {4'd0, k_ff} < 20'(PALETTE_DEPTH))
               data_in = (k_ff == 16'd0) ? 16'd0 : pal_rd;
            state_in = S_RSP;
         end
         S_RSP: if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; chan_ff <= 3'd3; used_ff <= 9'd1; ovf_ff <= 1'b0;
         done_ff <= 1'b0; taken_ff <= '0; pvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; used_ff <= used_in; ovf_ff <= ovf_in;
         done_ff <= done_in; taken_ff <= taken_in; pvalid_ff <= pvalid_in;
         if (csr_wr_en) chan_ff <= csr_wr_data;
      end
      col_ff <= col_in; last_ff <= last_in; k_ff <= k_in;
      ptr_ff <= ptr_in; sub_ff <= sub_in; data_ff <= data_in;
   end

   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = (state_ff == S_RSP);
   assign palette_count = used_ff;
   assign overflow      = ovf_ff;
   assign format        = fmt;
   assign image_done    = done_ff;
   assign pixel_count   = 17'(taken_ff);
   assign read_data     = data_ff;

   `ASSERT_IMPLIES(a_count_min, clock, reset, 1'b1, used_ff >= 9'd1)
   `ASSERT_IMPLIES(a_no_overlap, clock, reset, rsp_valid, req_stall)
   `ASSERT_NEXT(a_hold_rsp, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(read_data))
endmodule

### dv/palette_checker.sv
`timescale 1ns / 100ps

module palette_checker import ppal_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_wr_data,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [7:0]  red,
   input  logic [7:0]  green,
   input  logic [7:0]  blue,
   input  logic [7:0]  alpha,
   input  logic        last,
   input  logic [15:0] index,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [8:0]  palette_count,
   input  logic        overflow,
   input  logic [2:0]  format,
   input  logic        image_done,
   input  logic [16:0] pixel_count,
   input  logic [15:0] read_data,
   output int          fail_count,
   output int          results_due,
   output int          pushes_seen,
   output int          reads_seen,
   output int          overflows_seen
);

   typedef struct packed {
      logic [8:0]  palette_count;
      logic        overflow;
      logic [2:0]  format;
      logic        image_done;
      logic [16:0] pixel_count;
      logic [15:0] read_data;
   } status_type;

   status_type  status_q[$];
   logic [15:0] colour_mem[MAX_PIXELS_DEF];
   logic [7:0]  slot_mem[MAX_PIXELS_DEF];
   logic [15:0] pal_mem[PALETTE_DEPTH_DEF];
   int          pal_used;
   logic        pal_full;
   int          taken;
   logic        complete;
   logic [2:0]  chan_mode;

   function automatic logic [2:0] pick_format();
      if (pal_full) return (chan_mode == 3'd3) ? FMT_RGB : FMT_RGBA;
      if (pal_used <= 4) return FMT_2BPP;
      if (pal_used <= 16) return FMT_4BPP;
      return FMT_8BPP;
   endfunction

   function automatic int slot_at(int p);
      return (p < taken) ? int'(slot_mem[p]) : 0;
   endfunction

   function automatic void quantize_pixel();
      logic [15:0] col;
      int          slot;
      bit          hit;
      col = {(chan_mode == 3'd3) ? 1'b1 : alpha[7], blue[7:3], green[7:3], red[7:3]};
      slot = 0;
      hit = 0;
      if (complete) begin
         pal_used = 1;
         pal_full = 0;
         taken = 0;
         complete = 0;
      end
      if (taken < MAX_PIXELS_DEF) begin
         if (col[15] && !pal_full) begin
            for (int i = 1; i < pal_used && !hit; i++)
               if (pal_mem[i] == col) begin
                  slot = i;
                  hit = 1;
               end
            if (!hit) begin
               if (pal_used < PALETTE_DEPTH_DEF) begin
                  pal_mem[pal_used] = col;
                  slot = pal_used;
                  pal_used++;
               end else begin
                  pal_full = 1;
                  overflows_seen++;
               end
            end
         end
         colour_mem[taken] = col;
         slot_mem[taken] = slot[7:0];
         taken++;
      end
      if (last) complete = 1;
   endfunction

   function automatic logic [15:0] packed_image_word(int k);
      logic [2:0]  fmt;
      logic [15:0] v;
      fmt = pick_format();
      v = '0;
      if (fmt >= FMT_RGB) begin
         if (k < taken) v = colour_mem[k];
      end else if (fmt == FMT_8BPP) begin
         v = 16'(slot_at(k));
      end else if (fmt == FMT_4BPP) begin
         v = 16'((slot_at(2 * k) & 'hF) | ((slot_at(2 * k + 1) & 'hF) << 4));
      end else begin
         for (int j = 0; j < 4; j++) v |= 16'((slot_at(4 * k + j) & 'h3) << (2 * j));
      end
      return v;
   endfunction

   always @(posedge clock) begin
      status_type want, got;
      logic [15:0] rd;
      if (reset) begin
         status_q.delete();
         pal_mem[0] = '0;
         pal_used = 1;
         pal_full = 0;
         taken = 0;
         complete = 0;
         chan_mode = 3'd3;
         fail_count = 0;
         results_due = 0;
         pushes_seen = 0;
         reads_seen = 0;
         overflows_seen = 0;
      end else begin
         if (csr_wr_en) chan_mode = csr_wr_data;
         if (req_valid && !req_stall) begin
            rd = '0;
            case (req_type)
               REQ_PUSH: begin
                  quantize_pixel();
                  pushes_seen++;
               end
               REQ_IMG: begin
                  rd = packed_image_word(int'(index));
                  reads_seen++;
               end
               REQ_PAL: begin
                  if (index < pal_used) rd = pal_mem[index];
                  reads_seen++;
               end
               default: ;
            endcase
            want = '{palette_count: pal_used[8:0], overflow: pal_full,
                     format: pick_format(), image_done: complete,
                     pixel_count: taken[16:0], read_data: rd};
            status_q.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{palette_count, overflow, format, image_done, pixel_count, read_data};
            if (status_q.size() == 0) begin
               $error("result transaction with nothing expected");
               fail_count++;
            end else begin
               want = status_q.pop_front();
               if (got.palette_count !== want.palette_count) begin
                  $error("palette_count exp %0d got %0d", want.palette_count, got.palette_count);
                  fail_count++;
               end
               if (got.overflow !== want.overflow) begin
                  $error("overflow exp %0d got %0d", want.overflow, got.overflow);
                  fail_count++;
               end
               if (got.format !== want.format) begin
                  $error("format exp %0d got %0d", want.format, got.format);
                  fail_count++;
               end
               if (got.image_done !== want.image_done) begin
                  $error("image_done exp %0d got %0d", want.image_done, got.image_done);
                  fail_count++;
               end
               if (got.pixel_count !== want.pixel_count) begin
                  $error("pixel_count exp %0d got %0d", want.pixel_count, got.pixel_count);
                  fail_count++;
               end
               if (got.read_data !== want.read_data) begin
                  $error("read_data exp %h got %h", want.read_data, got.read_data);
                  fail_count++;
               end
            end
         end
         results_due = status_q.size();
      end
   end

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import ppal_pkg::*;

   // spare request code, the block must treat it as a no-op
   localparam logic [1:0] REQ_NOP = 2'd3;
   localparam int CYCLE_LIMIT = 4000000;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_wr_en = 0;
   logic [2:0]  csr_wr_data = 3'd3;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_type = REQ_PUSH;
   logic [7:0]  red = 0, green = 0, blue = 0, alpha = 0;
   logic        last = 0;
   logic [15:0] index = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [8:0]  palette_count;
   logic        overflow;
   logic [2:0]  format;
   logic        image_done;
   logic [16:0] pixel_count;
   logic [15:0] read_data;

   int fail_count, results_due, pushes_seen, reads_seen, overflows_seen;
   int send_idle_pct = 0, recv_idle_pct = 0;
   int hold_req = 0, hold_seen = 0, hold_left = 0;
   int cycle_cnt = 0;
   logic [23:0] colour_pool[64];
   int pool_size;

   pixel_palettizer u_top (.*);

   palette_checker u_chk (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("[pixel_palettizer] ERROR");
         $finish;
      end
   end

   // result side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // offer one transaction and wait until the block takes it
   task automatic send(input logic [1:0] t, input logic [31:0] rgba, input logic lst,
                       input logic [15:0] idx);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= t;
      {red, green, blue, alpha} <= rgba;
      last <= lst;
      index <= idx;
      do @(posedge clock); while (req_stall);
   endtask

   // drain everything, then settle and write the channels register
   task automatic set_channels(input logic [2:0] val);
      req_valid <= 1'b0;
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   // build a small pool so colours repeat and the palette size varies
   task automatic new_pool();
      int sizes[3] = '{3, 14, 64};
      pool_size = sizes[$urandom_range(2)];
      for (int i = 0; i < pool_size; i++) colour_pool[i] = 24'($urandom);
   endtask

   task automatic random_item();
      int          pick;
      logic [31:0] rgba;
      logic [15:0] idx;
      pick = $urandom_range(99);
      // keep the top five bits of each colour channel from the pool, jitter the rest
      rgba = {colour_pool[$urandom_range(pool_size - 1)], 8'h00} | ($urandom & 32'h0707_07FF);
      if ($urandom_range(9) == 0) rgba[7] = 1'($urandom);
      else rgba[7] = 1'b1;
      idx = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 80));
      if (pick < 60)      send(REQ_PUSH, rgba, $urandom_range(19) == 0, idx);
      else if (pick < 80) send(REQ_IMG, rgba, 1'($urandom_range(1)), idx);
      else if (pick < 96) send(REQ_PAL, rgba, 1'($urandom_range(1)), idx[15:0] & 16'h01FF);
      else                send(REQ_NOP, rgba, 1'($urandom_range(1)), idx);
   endtask

   initial begin
      int idle_plan[3][2] = '{'{25, 56}, '{56, 25}, '{0, 0}};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty state reads, spare code, all-zero and all-ones pixels
      send(REQ_PAL, 32'd0, 1'b0, 16'd0);
      send(REQ_IMG, 32'd0, 1'b0, 16'hFFFF);
      send(REQ_NOP, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
      send(REQ_PUSH, 32'h0000_0000, 1'b0, 16'd0);
      send(REQ_PUSH, 32'hFFFF_FFFF, 1'b0, 16'd0);
      send(REQ_PUSH, 32'h0000_0000, 1'b0, 16'd0);
      send(REQ_PUSH, 32'h1234_5600, 1'b1, 16'd0);
      send(REQ_IMG, 32'd0, 1'b0, 16'd0);
      send(REQ_IMG, 32'd0, 1'b0, 16'd1);
      send(REQ_PAL, 32'd0, 1'b0, 16'd2);
      send(REQ_PAL, 32'd0, 1'b0, 16'd3);
      // push after completion starts a new image
      send(REQ_PUSH, 32'h8080_8080, 1'b1, 16'd0);
      send(REQ_PAL, 32'd0, 1'b0, 16'd1);

      // rgba with an odd register value, alpha top bit decides transparency
      set_channels(3'd0);
      send(REQ_PUSH, 32'hFF00_007F, 1'b0, 16'd0);
      send(REQ_PUSH, 32'h00FF_0080, 1'b0, 16'd0);
      send(REQ_PUSH, 32'h0000_FFFF, 1'b1, 16'd0);
      send(REQ_IMG, 32'd0, 1'b0, 16'd0);
      send(REQ_PAL, 32'd0, 1'b0, 16'd2);

      // overflow: 257 distinct opaque colours, then direct reads
      set_channels(3'd3);
      for (int i = 0; i < 257; i++)
         send(REQ_PUSH, {i[4:0], 3'b000, i[8:5], 4'h0, 8'hFF, 8'h00}, i == 256, 16'd0);
      send(REQ_IMG, 32'd0, 1'b0, 16'd0);
      send(REQ_IMG, 32'd0, 1'b0, 16'd256);
      send(REQ_IMG, 32'd0, 1'b0, 16'd257);
      send(REQ_PAL, 32'd0, 1'b0, 16'd255);
      send(REQ_PAL, 32'd0, 1'b0, 16'd256);

      // another rgba register value, random alpha mixes in transparent pixels
      set_channels(3'd7);
      for (int i = 0; i < 8; i++)
         send(REQ_PUSH, $urandom, i == 7, 16'd0);
      send(REQ_IMG, 32'd0, 1'b0, 16'd0);
      send(REQ_IMG, 32'd0, 1'b0, 16'd1);

      set_channels(3'd4);
      // receiver holds off while requests keep coming
      hold_req++;
      for (int i = 0; i < 6; i++) send(REQ_PUSH, $urandom, 1'b0, 16'd0);
      req_valid <= 1'b0;
      wait_drained();

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = idle_plan[ph][0];
         recv_idle_pct = idle_plan[ph][1];
         for (int n = 0; n < 100; n++) begin
            if (n % 50 == 0) new_pool();
            random_item();
         end
         set_channels(ph == 0 ? 3'd3 : 3'd4);
      end

      req_valid <= 1'b0;
      wait_drained();
      $display("covered %0d pixel pushes and %0d reads, %0d palette overflows",
               pushes_seen, reads_seen, overflows_seen);
      $display("channels settings 0, 3, 4 and 7, three stall mixes, long result hold-off");
      if (fail_count == 0) begin
         $display("[pixel_palettizer] OK");
      end else begin
         $display("[pixel_palettizer] ERROR");
      end
      $finish;
   end

endmodule
